@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the trackball motion reporter modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while reset is released.
`define TBAM_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checks that a condition never holds on a rising clock edge outside reset.
`define TBAM_NEVER(label, expr, msg) \
    `TBAM_ASSERT(label, !(expr), msg)

`endif

@@ rtl/core/tbam_pkg.sv @@
// Shared constants, types and helper functions for the trackball motion reporter.
package tbam_pkg;

    // Size of the acceleration table and width of the motion accumulators.
    localparam int ACCEL_TABLE_DEPTH = 64;
    localparam int ACCUM_WIDTH       = 24;

    // Step lookup table.
    localparam int ROM_SIZE  = 45;
    localparam int ROM_AW    = $clog2(ROM_SIZE);
    localparam int STEP_W    = 12;
    localparam int SLOW_STEP = 3;

    localparam logic [STEP_W-1:0] STEP_ROM [ROM_SIZE] = '{
        12'd2693, 12'd2693, 12'd90, 12'd29, 12'd16, 12'd12, 12'd9, 12'd8, 12'd7,
        12'd6, 12'd6, 12'd6, 12'd5, 12'd5, 12'd5, 12'd5, 12'd5,
        12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4,
        12'd4, 12'd4, 12'd4, 12'd4,
        12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4, 12'd4,
        12'd4, 12'd4, 12'd4, 12'd4
    };

    // Movement gain and product widths.
    localparam int GAIN_W = 10;
    localparam int PROD_W = ACCUM_WIDTH + GAIN_W;

    // Products at or above 200 * 32768 always saturate the 16-bit output.
    localparam int LIM_W = 23;
    localparam logic [PROD_W-1:0] MOVE_SAT_LIMIT = PROD_W'(200 * 32768);

    // Division by 200: drop three bits, then multiply by ceil(2^25 / 25).
    localparam int QIN_W       = LIM_W - 3;
    localparam int RECIP_W     = 21;
    localparam int RECIP_SHIFT = 25;
    localparam logic [RECIP_W-1:0] RECIP_25 = 21'd1342178;
    localparam int QPROD_W     = QIN_W + RECIP_W;

    // Report kinds.
    localparam logic [1:0] KIND_MOVE    = 2'd0;
    localparam logic [1:0] KIND_SCROLL  = 2'd1;
    localparam logic [1:0] KIND_IDLE    = 2'd2;
    localparam logic [1:0] KIND_CLEARED = 2'd3;

    // Layers with a defined report.
    localparam logic [4:0] LAYER_MOVE   = 5'd0;
    localparam logic [4:0] LAYER_SCROLL = 5'd1;

    // Input commands.
    localparam logic CMD_EDGE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Queue between the front and back parts.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Operation handed from the front part to the back part.
    typedef struct packed {
        logic              is_tick;
        logic              is_x;
        logic              neg;
        logic [STEP_W-1:0] step;
        logic [4:0]        layer;
        logic [7:0]        brightness;
    } tbam_op_t;

    // Accelerated step for a time gap in milliseconds; a zero gap reads like one.
    function automatic logic [STEP_W-1:0] accel_step(input logic [31:0] delta);
        logic [STEP_W-1:0] s;
        s = STEP_W'(SLOW_STEP);
        if (delta < 32'(ROM_SIZE) && delta < 32'(ACCEL_TABLE_DEPTH)) begin
            s = STEP_ROM[delta[ROM_AW-1:0]];
        end
        return s;
    endfunction

    // Saturates an accumulator-width value to the signed 16-bit range.
    function automatic logic signed [15:0] sat16(input logic signed [ACCUM_WIDTH-1:0] v);
        logic signed [ACCUM_WIDTH-1:0] hi;
        logic signed [ACCUM_WIDTH-1:0] lo;
        logic signed [15:0]            r;
        hi = ACCUM_WIDTH'(32767);
        lo = -hi - ACCUM_WIDTH'(1);
        if (v > hi) begin
            r = 16'sh7fff;
        end else if (v < lo) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

@@ rtl/core/tbam_front.sv @@
// Front part: accepts sensor edges and report ticks and turns them into queue operations.
module tbam_front
    import tbam_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // channel, level, now_ms, layer, brightness
    input  logic [0:0]  s_axis_tuser,   // cmd
    output logic        op_valid,
    output tbam_op_t    op,
    input  logic        op_ready
);

    logic        cmd;
    logic [1:0]  channel;
    logic        level;
    logic [31:0] now_ms;
    logic [4:0]  layer;
    logic [7:0]  brightness;
    logic        accept;
    logic        changed;
    logic [31:0] delta;

    logic        last_level_reg [4];
    logic [31:0] last_edge_time_reg [4];

    // Unpack the request.
    assign cmd        = s_axis_tuser[0];
    assign channel    = s_axis_tdata[1:0];
    assign level      = s_axis_tdata[2];
    assign now_ms     = s_axis_tdata[34:3];
    assign layer      = s_axis_tdata[39:35];
    assign brightness = s_axis_tdata[47:40];

    // A request is taken whenever the queue has room; unchanged levels are dropped.
    assign s_axis_tready = op_ready;
    assign accept        = s_axis_tvalid && op_ready;
    assign changed       = (level != last_level_reg[channel]);
    assign delta         = now_ms - last_edge_time_reg[channel];
    assign op_valid      = s_axis_tvalid && ((cmd == CMD_TICK) || changed);

    // Build the operation for the back part.
    always_comb begin
        op.is_tick    = (cmd == CMD_TICK);
        op.is_x       = !channel[1];
        op.neg        = !channel[0];
        op.step       = accel_step(delta);
        op.layer      = layer;
        op.brightness = brightness;
    end

    // Per-channel level and time of the last real change.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                last_level_reg[i]     <= 1'b1;
                last_edge_time_reg[i] <= '0;
            end
        end else if (accept && cmd == CMD_EDGE && changed) begin
            last_level_reg[channel]     <= level;
            last_edge_time_reg[channel] <= now_ms;
        end
    end

endmodule

@@ rtl/core/tbam_fifo.sv @@
// Short queue of operations between the front and back parts.
`include "assert_macros.svh"
module tbam_fifo
    import tbam_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  tbam_op_t in_op,
    output logic     out_valid,
    input  logic     out_pop,
    output tbam_op_t out_op
);

    tbam_op_t           mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg;
    logic [FIFO_CW-1:0] count_next;
    logic               push;
    logic               pop;

    // Handshake on both sides.
    assign in_ready  = (count_reg != FIFO_CW'(FIFO_DEPTH));
    assign out_valid = (count_reg != '0);
    assign push      = in_valid && in_ready;
    assign pop       = out_pop && out_valid;
    assign out_op    = mem_reg[rd_ptr_reg];

    // Occupancy update.
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + FIFO_CW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - FIFO_CW'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_AW'(1);
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_op;
        end
    end

    `TBAM_NEVER(a_count_bound, count_reg > FIFO_CW'(FIFO_DEPTH), "queue count beyond depth")
    `TBAM_ASSERT(a_pop_count, (pop && !push) |=> (count_reg == $past(count_reg) - FIFO_CW'(1)), "pop did not lower count")

endmodule

@@ rtl/core/tbam_back.sv @@
// Back part: motion accumulators, report arithmetic and the result register.
`include "assert_macros.svh"
module tbam_back
    import tbam_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        op_valid,
    input  tbam_op_t    op,
    output logic        op_pop,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // x_value, y_value
    output logic [2:0]  m_axis_tuser    // kind, moving
);

    logic signed [ACCUM_WIDTH-1:0] x_acc_reg;
    logic signed [ACCUM_WIDTH-1:0] y_acc_reg;
    logic signed [ACCUM_WIDTH-1:0] x_acc_next;
    logic signed [ACCUM_WIDTH-1:0] y_acc_next;

    // Report stage registers.
    logic                 s1_valid_reg;
    logic [1:0]           s1_kind_reg;
    logic                 s1_moving_reg;
    logic                 s1_x_neg_reg;
    logic                 s1_y_neg_reg;
    logic [PROD_W-1:0]    s1_x_mag_reg;
    logic [PROD_W-1:0]    s1_y_mag_reg;
    logic signed [15:0]   s1_x_val_reg;
    logic signed [15:0]   s1_y_val_reg;

    // Result register.
    logic                 out_valid_reg;
    logic [1:0]           out_kind_reg;
    logic                 out_moving_reg;
    logic signed [15:0]   out_x_reg;
    logic signed [15:0]   out_y_reg;

    logic                 out_load;
    logic                 s1_free;
    logic                 tick_pop;
    logic                 edge_pop;
    logic                 any_motion;
    logic [GAIN_W-1:0]    gain;
    logic signed [ACCUM_WIDTH:0] sel_acc;
    logic signed [ACCUM_WIDTH:0] sum;
    logic signed [ACCUM_WIDTH-1:0] sum_sat;
    logic [ACCUM_WIDTH-1:0] x_abs;
    logic [ACCUM_WIDTH-1:0] y_abs;
    logic signed [ACCUM_WIDTH-1:0] x_half;
    logic signed [ACCUM_WIDTH-1:0] y_half;
    logic [1:0]           s1_kind_next;
    logic signed [15:0]   x_move;
    logic signed [15:0]   y_move;
    logic [QPROD_W-1:0]   x_qprod;
    logic [QPROD_W-1:0]   y_qprod;

    // Pipeline flow: a tick needs the report stage, an edge does not.
    assign out_load = !out_valid_reg || m_axis_tready;
    assign s1_free  = !s1_valid_reg || out_load;
    assign op_pop   = op_valid && (!op.is_tick || s1_free);
    assign tick_pop = op_pop && op.is_tick;
    assign edge_pop = op_pop && !op.is_tick;

    // Saturating add of a signed step into the selected accumulator.
    always_comb begin
        sel_acc = op.is_x ? (ACCUM_WIDTH+1)'(x_acc_reg) : (ACCUM_WIDTH+1)'(y_acc_reg);
        if (op.neg) begin
            sum = sel_acc - (ACCUM_WIDTH+1)'(op.step);
        end else begin
            sum = sel_acc + (ACCUM_WIDTH+1)'(op.step);
        end
        if (sum[ACCUM_WIDTH] != sum[ACCUM_WIDTH-1]) begin
            sum_sat = sum[ACCUM_WIDTH] ? {1'b1, {(ACCUM_WIDTH-1){1'b0}}}
                                       : {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
        end else begin
            sum_sat = sum[ACCUM_WIDTH-1:0];
        end
    end

    // Accumulator next values: edges add, ticks clear.
    always_comb begin
        x_acc_next = x_acc_reg;
        y_acc_next = y_acc_reg;
        if (tick_pop) begin
            x_acc_next = '0;
            y_acc_next = '0;
        end else if (edge_pop) begin
            if (op.is_x) begin
                x_acc_next = sum_sat;
            end else begin
                y_acc_next = sum_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_acc_reg <= '0;
            y_acc_reg <= '0;
        end else begin
            x_acc_reg <= x_acc_next;
            y_acc_reg <= y_acc_next;
        end
    end

    // Tick decode: report kind, magnitudes for the gain product, halves for scroll.
    assign any_motion = (x_acc_reg != '0) || (y_acc_reg != '0);
    assign gain   = GAIN_W'(120) + {1'b0, op.brightness, 1'b0} + {2'b00, op.brightness};
    assign x_abs  = x_acc_reg[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-x_acc_reg) : x_acc_reg;
    assign y_abs  = y_acc_reg[ACCUM_WIDTH-1] ? ACCUM_WIDTH'(-y_acc_reg) : y_acc_reg;
    assign x_half = (x_acc_reg + $signed(ACCUM_WIDTH'(x_acc_reg[ACCUM_WIDTH-1]))) >>> 1;
    assign y_half = (y_acc_reg + $signed(ACCUM_WIDTH'(y_acc_reg[ACCUM_WIDTH-1]))) >>> 1;

    always_comb begin
        if (!any_motion) begin
            s1_kind_next = KIND_IDLE;
        end else if (op.layer == LAYER_MOVE) begin
            s1_kind_next = KIND_MOVE;
        end else if (op.layer == LAYER_SCROLL) begin
            s1_kind_next = KIND_SCROLL;
        end else begin
            s1_kind_next = KIND_CLEARED;
        end
    end

    // Report stage: registered gain products and direct values.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_free) begin
            s1_valid_reg <= tick_pop;
        end
    end

    always_ff @(posedge aclk) begin
        if (tick_pop) begin
            s1_kind_reg   <= s1_kind_next;
            s1_moving_reg <= any_motion;
            s1_x_neg_reg  <= x_acc_reg[ACCUM_WIDTH-1];
            s1_y_neg_reg  <= y_acc_reg[ACCUM_WIDTH-1];
            s1_x_mag_reg  <= PROD_W'(x_abs) * PROD_W'(gain);
            s1_y_mag_reg  <= PROD_W'(y_abs) * PROD_W'(gain);
            if (s1_kind_next == KIND_SCROLL) begin
                s1_x_val_reg <= sat16(x_half);
                s1_y_val_reg <= sat16(y_half);
            end else begin
                s1_x_val_reg <= '0;
                s1_y_val_reg <= '0;
            end
        end
    end

    // Movement value: negate the product divided by 200, saturated to 16 bits.
    assign x_qprod = QPROD_W'(s1_x_mag_reg[LIM_W-1:3]) * QPROD_W'(RECIP_25);
    assign y_qprod = QPROD_W'(s1_y_mag_reg[LIM_W-1:3]) * QPROD_W'(RECIP_25);

    always_comb begin
        if (s1_x_mag_reg >= MOVE_SAT_LIMIT) begin
            x_move = s1_x_neg_reg ? 16'sh7fff : 16'sh8000;
        end else if (s1_x_neg_reg) begin
            x_move = {1'b0, x_qprod[RECIP_SHIFT+14:RECIP_SHIFT]};
        end else begin
            x_move = -{1'b0, x_qprod[RECIP_SHIFT+14:RECIP_SHIFT]};
        end
        if (s1_y_mag_reg >= MOVE_SAT_LIMIT) begin
            y_move = s1_y_neg_reg ? 16'sh7fff : 16'sh8000;
        end else if (s1_y_neg_reg) begin
            y_move = {1'b0, y_qprod[RECIP_SHIFT+14:RECIP_SHIFT]};
        end else begin
            y_move = -{1'b0, y_qprod[RECIP_SHIFT+14:RECIP_SHIFT]};
        end
    end

    // Result register toward the master side.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load && s1_valid_reg) begin
            out_kind_reg   <= s1_kind_reg;
            out_moving_reg <= s1_moving_reg;
            if (s1_kind_reg == KIND_MOVE) begin
                out_x_reg <= x_move;
                out_y_reg <= y_move;
            end else begin
                out_x_reg <= s1_x_val_reg;
                out_y_reg <= s1_y_val_reg;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_y_reg, out_x_reg};
    assign m_axis_tuser  = {out_moving_reg, out_kind_reg};

    `TBAM_ASSERT(a_tick_clears, tick_pop |=> (x_acc_reg == '0 && y_acc_reg == '0), "tick left motion behind")
    `TBAM_ASSERT(a_idle_zero, (out_valid_reg && out_kind_reg == KIND_IDLE) |-> (out_x_reg == '0 && out_y_reg == '0 && !out_moving_reg), "idle report not zero")
    `TBAM_ASSERT(a_moving_kind, (s1_valid_reg && s1_kind_reg != KIND_IDLE) |-> s1_moving_reg, "motion report without moving")

endmodule

@@ rtl/core/trackball_accel_motion_reporter.sv @@
// A report tick passes through a queue entry, the report stage and the result register before it shows on m_axis.
// Throughput: one request per cycle while the queue has room; sensor edges give no result and wait on m_axis only
// when they queue behind a tick whose report is stalled.
// A four-entry queue between the front part and the back part lets the two stall independently of each other.
// The gain product and the divide by 200 take one registered multiply stage each.
// Reset (aresetn low, synchronous) sets all levels high, timestamps and accumulators to zero,
// and empties the queue and the pipeline.
module trackball_accel_motion_reporter
    import tbam_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // channel[1:0], level[2], now_ms[34:3], layer[39:35], brightness[47:40]
    input  logic [0:0]  s_axis_tuser,   // cmd[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // x_value[15:0], y_value[31:16]
    output logic [2:0]  m_axis_tuser    // kind[1:0], moving[2]
);

    logic     fe_valid;
    logic     fe_ready;
    tbam_op_t fe_op;
    logic     q_valid;
    logic     q_pop;
    tbam_op_t q_op;

    // Request decode and per-channel timing.
    tbam_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .op_valid      (fe_valid),
        .op            (fe_op),
        .op_ready      (fe_ready)
    );

    // Decoupling queue.
    tbam_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fe_valid),
        .in_ready  (fe_ready),
        .in_op     (fe_op),
        .out_valid (q_valid),
        .out_pop   (q_pop),
        .out_op    (q_op)
    );

    // Accumulation and report generation.
    tbam_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .op_valid      (q_valid),
        .op            (q_op),
        .op_pop        (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

@@ tb/tb_trackball_accel_motion_reporter.sv @@
// Self-checking testbench for the trackball accelerated motion reporter.
module tb_trackball_accel_motion_reporter;
    import tbam_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int RANDOM_ITEMS  = 2000;
    localparam int FLOOD_EDGES   = 40;
    localparam int FAST_GAP_SPAN = 45;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [15:0] x_value;
        logic signed [15:0] y_value;
        logic               moving;
    } motion_report_t;

    // Tracks sensor state and accumulators, and holds the reports still owed by the block.
    class motion_scoreboard;
        longint         step_lut [FAST_GAP_SPAN];
        bit             pin_level [4];
        logic [31:0]    change_ms [4];
        longint         x_acc;
        longint         y_acc;
        bit             moving;
        motion_report_t expected_q [$];
        int             errors;

        function new();
            for (int d = 1; d < FAST_GAP_SPAN; d++) begin
                step_lut[d] = $rtoi(3.0 * (1.12 ** (60.0 / d)) + 0.5);
            end
            step_lut[0] = step_lut[1];
            for (int c = 0; c < 4; c++) begin
                pin_level[c] = 1'b1;
                change_ms[c] = '0;
            end
            x_acc  = 0;
            y_acc  = 0;
            moving = 1'b0;
            errors = 0;
        endfunction

        // Short gaps between changes give big steps; anything slower gives the base step.
        function longint step_for_gap(logic [31:0] gap);
            if (gap < FAST_GAP_SPAN) begin
                return step_lut[gap];
            end
            return 3;
        endfunction

        function longint clamp_acc(longint v);
            longint hi;
            hi = (longint'(1) << (ACCUM_WIDTH - 1)) - 1;
            if (v > hi) begin
                return hi;
            end
            if (v < -hi - 1) begin
                return -hi - 1;
            end
            return v;
        endfunction

        function logic signed [15:0] clamp16(longint v);
            if (v > 32767) begin
                return 16'sh7fff;
            end
            if (v < -32768) begin
                return 16'sh8000;
            end
            return v[15:0];
        endfunction

        function int pending_count();
            return expected_q.size();
        endfunction

        // Applies one accepted request; a tick queues the report it must produce.
        function void note_request(logic cmd, logic [1:0] ch, logic lvl, logic [31:0] now,
                                   logic [4:0] layer, logic [7:0] bright);
            motion_report_t r;
            longint         step;
            longint         gain;
            if (cmd == CMD_EDGE) begin
                if (lvl != pin_level[ch]) begin
                    step = step_for_gap(now - change_ms[ch]);
                    if (ch[0] == 1'b0) begin
                        step = -step;
                    end
                    if (ch < 2) begin
                        x_acc = clamp_acc(x_acc + step);
                    end else begin
                        y_acc = clamp_acc(y_acc + step);
                    end
                    pin_level[ch] = lvl;
                    change_ms[ch] = now;
                end
                return;
            end
            r = '0;
            if (x_acc != 0 || y_acc != 0) begin
                moving = 1'b1;
                if (layer == LAYER_MOVE) begin
                    gain = 120 + 3 * longint'(bright);
                    r.kind    = KIND_MOVE;
                    r.x_value = clamp16(-((x_acc * gain) / 200));
                    r.y_value = clamp16(-((y_acc * gain) / 200));
                end else if (layer == LAYER_SCROLL) begin
                    r.kind    = KIND_SCROLL;
                    r.x_value = clamp16(x_acc / 2);
                    r.y_value = clamp16(y_acc / 2);
                end else begin
                    r.kind = KIND_CLEARED;
                end
                x_acc = 0;
                y_acc = 0;
            end else begin
                r.kind = KIND_IDLE;
                moving = 1'b0;
            end
            r.moving = moving;
            expected_q.push_back(r);
        endfunction

        function void report_mismatch(string field, longint want, longint got);
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
            errors++;
        endfunction

        // Compares one report from the block with the oldest one owed.
        function void check_report(logic [1:0] kind, logic signed [15:0] x_value,
                                   logic signed [15:0] y_value, logic mv);
            motion_report_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected report, expected none, actual kind %0d x %0d y %0d",
                         $time, kind, x_value, y_value);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (kind !== e.kind) begin
                report_mismatch("kind", e.kind, kind);
            end
            if (x_value !== e.x_value) begin
                report_mismatch("x_value", e.x_value, x_value);
            end
            if (y_value !== e.y_value) begin
                report_mismatch("y_value", e.y_value, y_value);
            end
            if (mv !== e.moving) begin
                report_mismatch("moving", e.moving, mv);
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic [0:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;

    motion_scoreboard motion_sb;
    bit               steady;
    bit               drv_level [4] = '{1'b1, 1'b1, 1'b1, 1'b1};
    int               quiet_cycles;

    trackball_accel_motion_reporter i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial aclk = 1'b0;
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Presents one request, after a random gap unless steady, and holds it until the block takes it.
    task automatic send_request(input logic cmd, input logic [1:0] ch, input logic lvl,
                                input logic [31:0] now, input logic [4:0] layer,
                                input logic [7:0] bright);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap != 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  = {bright, layer, now, lvl, ch};
        s_axis_tuser  = cmd;
        s_axis_tvalid = 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        @(negedge aclk);
        s_axis_tvalid = 1'b0;
        if (cmd == CMD_EDGE) begin
            drv_level[ch] = lvl;
        end
    endtask

    // Sensor edges carry random tick fields, and ticks carry random edge fields.
    task automatic send_edge(input logic [1:0] ch, input logic lvl, input logic [31:0] now);
        send_request(CMD_EDGE, ch, lvl, now, $urandom_range(0, 31), $urandom_range(0, 255));
    endtask

    task automatic send_tick(input logic [4:0] layer, input logic [7:0] bright);
        send_request(CMD_TICK, $urandom_range(0, 3), $urandom_range(0, 1), $urandom, layer,
                     bright);
    endtask

    // Holds off new requests until every owed report has come out.
    task automatic wait_for_reports();
        while (motion_sb.pending_count() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    // Rapid changes on two channels at one timestamp drive both outputs to their limits.
    task automatic drive_flood(input logic [1:0] ch_a, input logic [1:0] ch_b,
                               input logic [4:0] layer);
        logic [31:0] stamp;
        stamp = $urandom;
        for (int k = 0; k < FLOOD_EDGES; k++) begin
            send_edge(ch_a, !drv_level[ch_a], stamp);
            send_edge(ch_b, !drv_level[ch_b], stamp);
        end
        send_tick(layer, $urandom_range(0, 255));
    endtask

    // Result side: a random stall before each report unless steady, then ready until it is taken.
    initial begin
        int stall;
        m_axis_tready = 1'b0;
        wait (aresetn);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 4);
            if (stall != 0) begin
                m_axis_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_axis_tready = 1'b1;
            do @(posedge aclk); while (!m_axis_tvalid);
            @(negedge aclk);
        end
    end

    // Bus monitor and watchdog on accepted requests and reports.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_axis_tvalid && m_axis_tready) begin
                motion_sb.check_report(m_axis_tuser[1:0], m_axis_tdata[15:0],
                                       m_axis_tdata[31:16], m_axis_tuser[2]);
            end
            if (s_axis_tvalid && s_axis_tready) begin
                motion_sb.note_request(s_axis_tuser[0], s_axis_tdata[1:0], s_axis_tdata[2],
                                       s_axis_tdata[34:3], s_axis_tdata[39:35],
                                       s_axis_tdata[47:40]);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
                quiet_cycles <= 0;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        logic [31:0] uptime;
        logic [1:0]  ch;
        logic        lvl;
        logic [4:0]  layer;
        int          r;
        motion_sb     = new();
        quiet_cycles  = 0;
        steady        = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // Directed: idle tick, repeated level, gap edges, timestamp wrap, every layer kind.
        send_tick(LAYER_MOVE, 8'd0);
        send_edge(2'd1, 1'b0, 32'd0);
        send_edge(2'd1, 1'b0, 32'd7);
        send_tick(LAYER_MOVE, 8'd255);
        send_edge(2'd0, 1'b0, 32'd5);
        send_edge(2'd2, 1'b0, 32'd44);
        send_edge(2'd3, 1'b0, 32'd45);
        send_tick(LAYER_SCROLL, 8'd17);
        send_edge(2'd0, 1'b1, 32'hffff_ffff);
        send_edge(2'd1, 1'b1, 32'd2);
        send_edge(2'd2, 1'b1, 32'd43);
        send_tick(5'd31, 8'd0);
        send_tick(LAYER_MOVE, 8'd128);
        send_edge(2'd3, 1'b1, 32'd46);
        send_edge(2'd0, 1'b0, 32'd3);
        send_tick(LAYER_MOVE, 8'd0);
        send_edge(2'd1, 1'b0, 32'd2);
        send_tick(5'd2, 8'd255);
        send_tick(LAYER_SCROLL, 8'd255);
        // Opposite slow steps cancel, so this tick finds no motion.
        send_edge(2'd1, 1'b1, 32'd1000);
        send_edge(2'd0, 1'b1, 32'd2000);
        send_tick(LAYER_MOVE, 8'd99);
        wait_for_reports();

        // Random traffic: mostly bursts of changes on one channel with ticks in between.
        uptime = $urandom;
        ch     = 2'd0;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 250 == 0) begin
                steady = ($urandom_range(0, 2) == 0);
            end
            if (i % 500 == 499) begin
                wait_for_reports();
            end
            if ($urandom_range(0, 7) == 0) begin
                r = $urandom_range(0, 9);
                layer = (r < 4) ? LAYER_MOVE : (r < 7) ? LAYER_SCROLL : $urandom_range(0, 31);
                send_tick(layer, $urandom_range(0, 255));
            end else begin
                if ($urandom_range(0, 9) >= 7) begin
                    ch = $urandom_range(0, 3);
                end
                r = $urandom_range(0, 19);
                if (r < 8) begin
                    uptime = uptime + $urandom_range(0, 3);
                end else if (r < 16) begin
                    uptime = uptime + $urandom_range(4, 44);
                end else if (r < 19) begin
                    uptime = uptime + $urandom_range(45, 300);
                end else begin
                    uptime = $urandom;
                end
                lvl = ($urandom_range(0, 9) == 0) ? drv_level[ch] : !drv_level[ch];
                send_edge(ch, lvl, uptime);
            end
        end

        // Output saturation: x at its negative limit and y at its positive limit, in move and in scroll reports.
        steady = 1'b0;
        wait_for_reports();
        drive_flood(2'd1, 2'd2, LAYER_MOVE);
        drive_flood(2'd0, 2'd3, LAYER_SCROLL);

        while (motion_sb.pending_count() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (motion_sb.errors == 0 && motion_sb.pending_count() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
